// File: src/lvrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lvrs_pkg;

	localparam int unsigned DIM_W  = 14;
	localparam int unsigned REND_W = 15;
	localparam int unsigned POS_W  = 15;
	localparam int unsigned EDGE_W = 16;
	localparam int unsigned MAG_W  = 15;
	localparam int unsigned PROD_W = 30;
	localparam int unsigned DVD_W  = 32;
	localparam int unsigned DSR_W  = 15;
	localparam int unsigned CNT_W  = 5;
	localparam int unsigned OUT_W  = 30;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic [0:0] REG_RENDER_WIDTH  = 1'b0;
	localparam logic [0:0] REG_RENDER_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		OP_FRAME    = 3'd0,
		OP_VIEWPORT = 3'd1,
		OP_ARM      = 3'd2,
		OP_SCALE    = 3'd3,
		OP_RESET    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_ISSUE,
		SQ_WAIT,
		SQ_HOLD
	} seq_state_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_MUL,
		SC_DIV,
		SC_WAIT
	} scl_state_t;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [DSR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DVD_W-1:0]  quotient;
	} div_rsp_t;

	typedef struct packed {
		logic              start;
		logic [EDGE_W-1:0] pos;
		logic [REND_W-1:0] num;
		logic [DIM_W-1:0]  den;
	} scl_req_t;

	typedef struct packed {
		logic              done;
		logic [OUT_W-1:0]  value;
	} scl_rsp_t;

endpackage

`default_nettype wire

// File: src/lvrs_div.sv
`timescale 1ns / 1ps
`default_nettype none

module lvrs_div (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire lvrs_pkg::div_req_t req,
	output lvrs_pkg::div_rsp_t   rsp
);

	logic                         run_q;
	logic                         done_q;
	logic [lvrs_pkg::CNT_W-1:0]   cnt_q;
	logic [lvrs_pkg::DVD_W-1:0]   quo_q;
	logic [lvrs_pkg::DSR_W-1:0]   rem_q;
	logic [lvrs_pkg::DSR_W-1:0]   dsr_q;
	logic [lvrs_pkg::DSR_W:0]     shifted;
	logic [lvrs_pkg::DSR_W:0]     diff;
	logic                         ge;

	assign shifted = {rem_q, quo_q[lvrs_pkg::DVD_W-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {lvrs_pkg::CNT_W{1'b1}}) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[lvrs_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? diff[lvrs_pkg::DSR_W-1:0] : shifted[lvrs_pkg::DSR_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

// File: src/lvrs_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module lvrs_scale (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire lvrs_pkg::scl_req_t req,
	output lvrs_pkg::scl_rsp_t   rsp
);

	lvrs_pkg::scl_state_t          state_q;
	lvrs_pkg::scl_state_t          state_d;
	logic [lvrs_pkg::EDGE_W-1:0]   pos_q;
	logic [lvrs_pkg::MAG_W-1:0]    mag_q;
	logic                          neg_q;
	logic [lvrs_pkg::REND_W-1:0]   num_q;
	logic [lvrs_pkg::DIM_W-1:0]    den_q;
	logic [lvrs_pkg::PROD_W-1:0]   prod_q;
	logic [lvrs_pkg::EDGE_W-1:0]   abs_pos;
	lvrs_pkg::div_req_t            div_req;
	lvrs_pkg::div_rsp_t            div_rsp;
	logic [lvrs_pkg::DVD_W-1:0]    quo;
	logic [lvrs_pkg::OUT_W-1:0]    value;

	assign abs_pos = req.pos[lvrs_pkg::EDGE_W-1] ? (~req.pos + 1'b1) : req.pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lvrs_pkg::SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			pos_q <= req.pos;
			mag_q <= abs_pos[lvrs_pkg::MAG_W-1:0];
			neg_q <= req.pos[lvrs_pkg::EDGE_W-1];
			num_q <= req.num;
			den_q <= req.den;
		end
		if (state_q == lvrs_pkg::SC_MUL) begin
			prod_q <= mag_q * num_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lvrs_pkg::SC_IDLE: begin
				if (req.start) begin
					state_d = lvrs_pkg::SC_MUL;
				end
			end
			lvrs_pkg::SC_MUL: begin
				state_d = lvrs_pkg::SC_DIV;
			end
			lvrs_pkg::SC_DIV: begin
				state_d = lvrs_pkg::SC_WAIT;
			end
			lvrs_pkg::SC_WAIT: begin
				if (div_rsp.done) begin
					state_d = lvrs_pkg::SC_IDLE;
				end
			end
			default: begin
				state_d = lvrs_pkg::SC_IDLE;
			end
		endcase
	end

	always_comb begin
		div_req.start    = state_q == lvrs_pkg::SC_DIV;
		div_req.dividend = {1'b0, prod_q, 1'b0} +
			{{(lvrs_pkg::DVD_W - lvrs_pkg::DIM_W){1'b0}}, den_q};
		div_req.divisor  = {den_q, 1'b0};
	end

	lvrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign quo = div_rsp.quotient;

	always_comb begin
		if (den_q == '0) begin
			value = {{(lvrs_pkg::OUT_W - lvrs_pkg::EDGE_W){pos_q[lvrs_pkg::EDGE_W-1]}}, pos_q};
		end else if (neg_q) begin
			if (|quo[lvrs_pkg::DVD_W-1:lvrs_pkg::OUT_W-1]) begin
				value = lvrs_pkg::OUT_MIN;
			end else begin
				value = {lvrs_pkg::OUT_W{1'b0}} - {1'b0, quo[lvrs_pkg::OUT_W-2:0]};
			end
		end else begin
			if (|quo[lvrs_pkg::DVD_W-1:lvrs_pkg::OUT_W-1]) begin
				value = lvrs_pkg::OUT_MAX;
			end else begin
				value = {1'b0, quo[lvrs_pkg::OUT_W-2:0]};
			end
		end
	end

	assign rsp.done  = (state_q == lvrs_pkg::SC_WAIT) && div_rsp.done;
	assign rsp.value = value;

endmodule

`default_nettype wire

// File: src/latched_viewport_rect_scaler.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Payload
// in        in_valid / in_stall       opcode, rect_x, rect_y, rect_width, rect_height,
//                                     target_ready
// out       out_valid / out_stall     out_x, out_y, out_width, out_height, active,
//                                     release_binding
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Every request except an armed scale registers its result in the cycle after acceptance.
// An armed scale runs the left, right, top and bottom edges in turn through one shared
// multiply and radix-2 divide unit with a 32-step divider; its result is registered once
// the last edge is done and the output is free. No new request is taken until then.
// The asynchronous reset clears all tracking state and both render registers.
// A stalled output holds its result; a request that needs the output register waits.

module latched_viewport_rect_scaler (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [2:0]                         opcode,
	input  wire  signed [lvrs_pkg::POS_W-1:0]  rect_x,
	input  wire  signed [lvrs_pkg::POS_W-1:0]  rect_y,
	input  wire  [lvrs_pkg::DIM_W-1:0]         rect_width,
	input  wire  [lvrs_pkg::DIM_W-1:0]         rect_height,
	input  wire                                target_ready,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic signed [lvrs_pkg::OUT_W-1:0]  out_x,
	output logic signed [lvrs_pkg::OUT_W-1:0]  out_y,
	output logic signed [lvrs_pkg::OUT_W-1:0]  out_width,
	output logic signed [lvrs_pkg::OUT_W-1:0]  out_height,
	output logic                               active,
	output logic                               release_binding,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [0:0]                         cfg_index,
	input  wire  [lvrs_pkg::REND_W-1:0]        cfg_data
);

	lvrs_pkg::seq_state_t          seq_q;
	lvrs_pkg::seq_state_t          seq_d;
	logic [lvrs_pkg::REND_W-1:0]   render_w_q;
	logic [lvrs_pkg::REND_W-1:0]   render_h_q;
	logic [lvrs_pkg::DIM_W-1:0]    ref_w_q;
	logic [lvrs_pkg::DIM_W-1:0]    ref_h_q;
	logic                          have_ref_q;
	logic                          expect_first_q;
	logic                          armed_q;
	logic [lvrs_pkg::DIM_W-1:0]    frz_w_q;
	logic [lvrs_pkg::DIM_W-1:0]    frz_h_q;
	logic [lvrs_pkg::DIM_W-1:0]    ref_w_d;
	logic [lvrs_pkg::DIM_W-1:0]    ref_h_d;
	logic                          have_ref_d;
	logic                          expect_first_d;
	logic                          armed_d;
	logic [lvrs_pkg::DIM_W-1:0]    frz_w_d;
	logic [lvrs_pkg::DIM_W-1:0]    frz_h_d;
	logic                          release_d;
	logic                          arm_ok;
	logic                          is_scale;
	logic                          scale_go;
	logic                          accept;
	logic                          out_free;
	logic                          load_direct;
	logic                          load_hold;
	logic [1:0]                    idx_q;
	logic [lvrs_pkg::POS_W-1:0]    rx_q;
	logic [lvrs_pkg::POS_W-1:0]    ry_q;
	logic [lvrs_pkg::DIM_W-1:0]    rw_q;
	logic [lvrs_pkg::DIM_W-1:0]    rh_q;
	logic [lvrs_pkg::OUT_W-1:0]    res_q [0:3];
	logic [lvrs_pkg::EDGE_W-1:0]   edge_x;
	logic [lvrs_pkg::EDGE_W-1:0]   edge_y;
	logic [lvrs_pkg::OUT_W:0]      diff_w;
	logic [lvrs_pkg::OUT_W:0]      diff_h;
	logic [lvrs_pkg::OUT_W-1:0]    sat_w;
	logic [lvrs_pkg::OUT_W-1:0]    sat_h;
	lvrs_pkg::scl_req_t            scl_req;
	lvrs_pkg::scl_rsp_t            scl_rsp;
	logic                          out_valid_q;
	logic [lvrs_pkg::OUT_W-1:0]    out_x_q;
	logic [lvrs_pkg::OUT_W-1:0]    out_y_q;
	logic [lvrs_pkg::OUT_W-1:0]    out_w_q;
	logic [lvrs_pkg::OUT_W-1:0]    out_h_q;
	logic                          active_q;
	logic                          release_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			render_w_q <= '0;
			render_h_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lvrs_pkg::REG_RENDER_WIDTH:  render_w_q <= cfg_data;
				lvrs_pkg::REG_RENDER_HEIGHT: render_h_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign is_scale = opcode == lvrs_pkg::OP_SCALE;
	assign scale_go = is_scale && armed_q;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (seq_q != lvrs_pkg::SQ_IDLE) || (!out_free && !scale_go);
	assign accept   = in_valid && !in_stall;

	assign arm_ok = target_ready && have_ref_q &&
		(render_w_q >= {1'b0, ref_w_q}) && (render_h_q >= {1'b0, ref_h_q});

	always_comb begin
		ref_w_d        = ref_w_q;
		ref_h_d        = ref_h_q;
		have_ref_d     = have_ref_q;
		expect_first_d = expect_first_q;
		armed_d        = armed_q;
		frz_w_d        = frz_w_q;
		frz_h_d        = frz_h_q;
		release_d      = 1'b0;
		case (lvrs_pkg::op_t'(opcode))
			lvrs_pkg::OP_FRAME: begin
				expect_first_d = 1'b1;
			end
			lvrs_pkg::OP_VIEWPORT: begin
				if (expect_first_q) begin
					expect_first_d = 1'b0;
					if (armed_q && (rect_width != frz_w_q || rect_height != frz_h_q)) begin
						armed_d   = 1'b0;
						frz_w_d   = '0;
						frz_h_d   = '0;
						release_d = 1'b1;
					end
					if (rect_width != '0 && rect_height != '0) begin
						ref_w_d    = rect_width;
						ref_h_d    = rect_height;
						have_ref_d = 1'b1;
					end
				end
			end
			lvrs_pkg::OP_ARM: begin
				armed_d = arm_ok;
				frz_w_d = arm_ok ? ref_w_q : '0;
				frz_h_d = arm_ok ? ref_h_q : '0;
			end
			lvrs_pkg::OP_RESET: begin
				ref_w_d        = '0;
				ref_h_d        = '0;
				have_ref_d     = 1'b0;
				expect_first_d = 1'b0;
				armed_d        = 1'b0;
				frz_w_d        = '0;
				frz_h_d        = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_w_q        <= '0;
			ref_h_q        <= '0;
			have_ref_q     <= 1'b0;
			expect_first_q <= 1'b0;
			armed_q        <= 1'b0;
			frz_w_q        <= '0;
			frz_h_q        <= '0;
		end else if (accept) begin
			ref_w_q        <= ref_w_d;
			ref_h_q        <= ref_h_d;
			have_ref_q     <= have_ref_d;
			expect_first_q <= expect_first_d;
			armed_q        <= armed_d;
			frz_w_q        <= frz_w_d;
			frz_h_q        <= frz_h_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= lvrs_pkg::SQ_IDLE;
			idx_q <= '0;
		end else begin
			seq_q <= seq_d;
			if (accept && scale_go) begin
				idx_q <= '0;
			end else if (seq_q == lvrs_pkg::SQ_WAIT && scl_rsp.done) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && scale_go) begin
			rx_q <= rect_x;
			ry_q <= rect_y;
			rw_q <= rect_width;
			rh_q <= rect_height;
		end
		if (seq_q == lvrs_pkg::SQ_WAIT && scl_rsp.done) begin
			res_q[idx_q] <= scl_rsp.value;
		end
	end

	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			lvrs_pkg::SQ_IDLE: begin
				if (accept && scale_go) begin
					seq_d = lvrs_pkg::SQ_ISSUE;
				end
			end
			lvrs_pkg::SQ_ISSUE: begin
				seq_d = lvrs_pkg::SQ_WAIT;
			end
			lvrs_pkg::SQ_WAIT: begin
				if (scl_rsp.done) begin
					seq_d = (idx_q == 2'd3) ? lvrs_pkg::SQ_HOLD : lvrs_pkg::SQ_ISSUE;
				end
			end
			lvrs_pkg::SQ_HOLD: begin
				if (out_free) begin
					seq_d = lvrs_pkg::SQ_IDLE;
				end
			end
			default: begin
				seq_d = lvrs_pkg::SQ_IDLE;
			end
		endcase
	end

	always_comb begin
		edge_x = idx_q[0] ? ({rx_q[lvrs_pkg::POS_W-1], rx_q} + {2'b00, rw_q})
			: {rx_q[lvrs_pkg::POS_W-1], rx_q};
		edge_y = idx_q[0] ? ({ry_q[lvrs_pkg::POS_W-1], ry_q} + {2'b00, rh_q})
			: {ry_q[lvrs_pkg::POS_W-1], ry_q};
		scl_req.start = seq_q == lvrs_pkg::SQ_ISSUE;
		scl_req.pos   = idx_q[1] ? edge_y : edge_x;
		scl_req.num   = idx_q[1] ? render_h_q : render_w_q;
		scl_req.den   = idx_q[1] ? frz_h_q : frz_w_q;
	end

	lvrs_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (scl_req),
		.rsp    (scl_rsp)
	);

	always_comb begin
		diff_w = {res_q[1][lvrs_pkg::OUT_W-1], res_q[1]} - {res_q[0][lvrs_pkg::OUT_W-1], res_q[0]};
		diff_h = {res_q[3][lvrs_pkg::OUT_W-1], res_q[3]} - {res_q[2][lvrs_pkg::OUT_W-1], res_q[2]};
		if (diff_w[lvrs_pkg::OUT_W] != diff_w[lvrs_pkg::OUT_W-1]) begin
			sat_w = diff_w[lvrs_pkg::OUT_W] ? lvrs_pkg::OUT_MIN : lvrs_pkg::OUT_MAX;
		end else begin
			sat_w = diff_w[lvrs_pkg::OUT_W-1:0];
		end
		if (diff_h[lvrs_pkg::OUT_W] != diff_h[lvrs_pkg::OUT_W-1]) begin
			sat_h = diff_h[lvrs_pkg::OUT_W] ? lvrs_pkg::OUT_MIN : lvrs_pkg::OUT_MAX;
		end else begin
			sat_h = diff_h[lvrs_pkg::OUT_W-1:0];
		end
	end

	assign load_direct = accept && !scale_go;
	assign load_hold   = (seq_q == lvrs_pkg::SQ_HOLD) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_direct || load_hold) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_hold) begin
			out_x_q   <= res_q[0];
			out_y_q   <= res_q[2];
			out_w_q   <= sat_w;
			out_h_q   <= sat_h;
			active_q  <= armed_q;
			release_q <= 1'b0;
		end else if (load_direct) begin
			if (is_scale) begin
				out_x_q <= {{(lvrs_pkg::OUT_W - lvrs_pkg::POS_W){rect_x[lvrs_pkg::POS_W-1]}}, rect_x};
				out_y_q <= {{(lvrs_pkg::OUT_W - lvrs_pkg::POS_W){rect_y[lvrs_pkg::POS_W-1]}}, rect_y};
				out_w_q <= {{(lvrs_pkg::OUT_W - lvrs_pkg::DIM_W){1'b0}}, rect_width};
				out_h_q <= {{(lvrs_pkg::OUT_W - lvrs_pkg::DIM_W){1'b0}}, rect_height};
			end else begin
				out_x_q <= '0;
				out_y_q <= '0;
				out_w_q <= '0;
				out_h_q <= '0;
			end
			active_q  <= armed_d;
			release_q <= release_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_x           = out_x_q;
	assign out_y           = out_y_q;
	assign out_width       = out_w_q;
	assign out_height      = out_h_q;
	assign active          = active_q;
	assign release_binding = release_q;

endmodule

`default_nettype wire
